@@ design/radar_bin_value_decoder_macros.svh @@
// Assertion helpers shared by the decoder RTL.
// Every check samples on the rising edge of i_clk and is off while reset is held.
`ifndef RADAR_BIN_VALUE_DECODER_MACROS_SVH
`define RADAR_BIN_VALUE_DECODER_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define RBVD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define RBVD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rbvd_pkg.sv @@
`timescale 1ns / 1ps
package rbvd_pkg;

    // Data kind codes; codes 6 and 7 mean nothing and decode as unsupported.
    localparam logic [2:0] KIND_REFL  = 3'd0;
    localparam logic [2:0] KIND_VEL   = 3'd1;
    localparam logic [2:0] KIND_ECHO  = 3'd2;
    localparam logic [2:0] KIND_VIL   = 3'd3;
    localparam logic [2:0] KIND_LIQ   = 3'd4;
    localparam logic [2:0] KIND_UNSUP = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DATA_KIND = 2'd0;
    localparam logic [1:0] CFG_NYQUIST   = 2'd1;

    localparam int CODE_W  = 16;
    localparam int NYQ_W   = 20;
    localparam int VALUE_W = 28;

    // ceil(2^27 / 127): exact floor(x / 127) for any 20-bit x after >> 27.
    localparam logic [20:0] NYQ_RECIP = 21'd1056833;
    localparam int          NYQ_SHIFT = 27;

    typedef enum logic [2:0] {
        ST_VALID  = 3'd0,
        ST_NODATA = 3'd1,
        ST_NA     = 3'd2,
        ST_VEL0   = 3'd3,
        ST_VEL1   = 3'd4,
        ST_UNSUP  = 3'd5
    } t_status;

    // Front-stage result handed to the velocity scaling stage.
    typedef struct packed {
        t_status                     status;
        logic signed [VALUE_W-1:0]   value;  // final value for non-velocity kinds
        logic                        vel;    // velocity code that needs scaling
        logic                        neg;    // code below 128
        logic [6:0]                  mag;    // |code - 128|
        logic [13:0]                 nyq_q;  // nyquist / 127
        logic [6:0]                  nyq_r;  // nyquist % 127
    } t_mid;

endpackage

@@ design/radar_bin_value_decoder.sv @@
`timescale 1ns / 1ps
// Radar bin value decoder: turns one raw bin code into a signed value in
// thousandths of the unit, or a status code for reserved codes.
// Input channel: i_valid / i_raw_code, held off by o_stall. A beat is taken
// on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / o_value_milli / o_status, held off by i_stall.
// A beat leaves on a rising edge with o_valid high and i_stall low.
// Throughput is one beat per cycle while i_stall is low. Two registers: the
// input register holds the code, and one pass of decode and velocity scaling
// loads the result register.
// The nyquist split by 127 is done once, when the register is written, so
// the per-beat path only multiplies small operands.
// A stage loads when it is empty or draining, so o_stall rises only when
// both registers are full and i_stall is high; held beats keep their payload.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 data
// kind, 1 nyquist in mm/s); other indexes are dropped. Write only while no
// beat is in flight.
// Reset (synchronous, active low) empties the pipe and clears both registers
// to zero (reflectivity kind, nyquist 0).
`include "radar_bin_value_decoder_macros.svh"
module radar_bin_value_decoder
    import rbvd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [CODE_W-1:0]         i_raw_code,
    output logic                      o_stall,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_value_milli,
    output logic [2:0]                o_status,
    input  logic                      i_stall,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [NYQ_W-1:0]          i_cfg_data
);

    // configuration registers; nyquist is kept as quotient and remainder by 127
    logic [2:0]  r_data_kind;
    logic [13:0] r_nyq_q;
    logic [6:0]  r_nyq_r;

    // split of the written nyquist value
    logic [40:0]      cfg_prod;
    logic [13:0]      cfg_q;
    logic [NYQ_W-1:0] cfg_r;

    // stage valids and payloads
    logic                      r_v1, r_v2;
    logic [CODE_W-1:0]         r_code;
    logic signed [VALUE_W-1:0] r_value;
    t_status                   r_status;

    logic                      adv1, adv2;
    t_mid                      n_mid;
    logic signed [VALUE_W-1:0] n_value;
    t_status                   n_status;

    // A stage loads when it is empty or its contents move on.
    assign adv2 = !r_v2 || !i_stall;
    assign adv1 = !r_v1 || adv2;

    assign o_stall       = !adv1;
    assign o_valid       = r_v2;
    assign o_value_milli = r_value;
    assign o_status      = r_status;

    // Split nyquist into quotient and remainder by 127.
    assign cfg_prod = 41'(i_cfg_data) * 41'(NYQ_RECIP);
    assign cfg_q    = cfg_prod[40:NYQ_SHIFT];
    assign cfg_r    = i_cfg_data - 20'({cfg_q, 7'd0}) + 20'(cfg_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_kind <= KIND_REFL;
            r_nyq_q     <= '0;
            r_nyq_r     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DATA_KIND: r_data_kind <= i_cfg_data[2:0];
                CFG_NYQUIST: begin
                    r_nyq_q <= cfg_q;
                    r_nyq_r <= cfg_r[6:0];
                end
                default:       ;
            endcase
        end
    end

    rbvd_decode u_decode (
        .i_code    (r_code),
        .i_kind    (r_data_kind),
        .i_nyq_q   (r_nyq_q),
        .i_nyq_r   (r_nyq_r),
        .o_mid     (n_mid)
    );

    rbvd_scale u_scale (
        .i_mid    (n_mid),
        .o_value  (n_value),
        .o_status (n_status)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    // payload: hold while the stage is blocked
    always_ff @(posedge i_clk) begin
        if (adv1) r_code <= i_raw_code;
        if (adv2) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    `RBVD_ASSERT_SAME(a_zero_on_status,
        o_valid && (o_status != ST_VALID), o_value_milli == '0,
        "value must be zero when status is set")
    `RBVD_ASSERT_SAME(a_stall_only_full,
        o_stall, r_v1 && r_v2,
        "input stalled while pipe has room")
    `RBVD_ASSERT_NEXT(a_accept_loads,
        i_valid && !o_stall, r_v1,
        "accepted beat lost at input stage")

endmodule

@@ design/rbvd_decode.sv @@
`timescale 1ns / 1ps
module rbvd_decode
    import rbvd_pkg::*;
(
    input  logic [CODE_W-1:0] i_code,
    input  logic [2:0]        i_kind,
    input  logic [13:0]       i_nyq_q,
    input  logic [6:0]        i_nyq_r,
    output t_mid              o_mid
);

    logic [7:0]                b;
    logic signed [VALUE_W-1:0] b_s;
    logic [3:0]                liq_exp;
    logic [11:0]               liq_mant;
    logic [3:0]                liq_sh;
    logic [VALUE_W-1:0]        liq_norm;

    assign b        = i_code[7:0];
    assign b_s      = signed'({20'd0, b});
    assign liq_exp  = i_code[15:12];
    assign liq_mant = i_code[11:0];
    assign liq_sh   = liq_exp - 4'd1;
    assign liq_norm = {15'd0, 1'b1, liq_mant} << liq_sh;

    always_comb begin
        o_mid        = '0;
        o_mid.status = ST_VALID;
        o_mid.nyq_q  = i_nyq_q;
        o_mid.nyq_r  = i_nyq_r;
        o_mid.neg    = ~b[7];
        o_mid.mag    = b[7] ? 7'(b - 8'd128) : 7'(8'd128 - b);
        unique case (i_kind)
            KIND_REFL: begin
                if (b == 8'hFF) o_mid.status = ST_NODATA;
                else            o_mid.value  = (b_s - 28'sd64) * 28'sd500;
            end
            KIND_VEL: begin
                if (b == 8'd0)       o_mid.status = ST_VEL0;
                else if (b == 8'd1)  o_mid.status = ST_VEL1;
                else if (b == 8'hFF) o_mid.status = ST_NODATA;
                else                 o_mid.vel    = 1'b1;
            end
            KIND_ECHO: begin
                if (b == 8'hFF)     o_mid.status = ST_NODATA;
                else if (b == 8'd0) o_mid.status = ST_NA;
                else                o_mid.value  = (b_s - 28'sd1) * 28'sd100;
            end
            KIND_VIL: begin
                if (i_code == 16'hFFFF)  o_mid.status = ST_NODATA;
                else if (i_code == '0)   o_mid.status = ST_NA;
                else o_mid.value = signed'({12'd0, i_code}) - 28'sd1;
            end
            KIND_LIQ: begin
                if (i_code == 16'hFFFF)   o_mid.status = ST_NODATA;
                else if (liq_exp == 4'd0) o_mid.value  = signed'({16'd0, liq_mant});
                else                      o_mid.value  = signed'(liq_norm);
            end
            default: begin
                o_mid.status = ST_UNSUP;
            end
        endcase
    end

endmodule

@@ design/rbvd_scale.sv @@
`timescale 1ns / 1ps
module rbvd_scale
    import rbvd_pkg::*;
(
    input  t_mid                      i_mid,
    output logic signed [VALUE_W-1:0] o_value,
    output t_status                   o_status
);

    // nyq*d/127 = d*q + floor(d*r/127), with nyq = 127*q + r.
    logic [13:0]               rem_prod;
    logic [14:0]               rem_inc;
    logic [21:0]               rem_scaled;
    logic [6:0]                rem_quot;
    logic [20:0]               main_prod;
    logic [20:0]               vel_mag;
    logic signed [VALUE_W-1:0] vel_pos;

    assign rem_prod   = 14'(i_mid.mag) * 14'(i_mid.nyq_r);
    assign rem_inc    = 15'(rem_prod) + 15'd1;
    // floor((y+1)*129 / 2^14) == floor(y/127) for y below 16383
    assign rem_scaled = 22'({rem_inc, 7'd0}) + 22'(rem_inc);
    assign rem_quot   = rem_scaled[20:14];
    assign main_prod  = 21'(i_mid.mag) * 21'(i_mid.nyq_q);
    assign vel_mag    = main_prod + 21'(rem_quot);
    assign vel_pos    = signed'(28'(vel_mag));

    always_comb begin
        o_status = i_mid.status;
        if (i_mid.vel) begin
            o_value = i_mid.neg ? -vel_pos : vel_pos;
        end else begin
            o_value = i_mid.value;
        end
    end

endmodule
